/* src/sfr_pkg.sv */
// Shared constants and types for the SBUS frame receiver.
package sfr_pkg;

  localparam int unsigned NUM_CH     = 16;
  localparam int unsigned CH_W       = 11;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned DATA_BYTES = 23;              // bytes 1..23 held in the shift line
  localparam int unsigned SR_W       = DATA_BYTES * BYTE_W;
  localparam int unsigned OUT_DW     = 24;               // 17 payload bits padded to bytes
  localparam int unsigned CFG_AW     = 1;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0] END_BYTE    = 8'h00;
  localparam logic [POS_W-1:0]  POS_HUNT    = 5'd0;
  localparam logic [POS_W-1:0]  POS_END     = 5'd24;     // next byte is the end byte
  localparam logic [POS_W-1:0]  POS_BAD     = 5'd25;     // drop one byte after a bad end byte

  localparam logic [CH_W-1:0]  THRESH_RST = 11'd800;
  localparam logic [IDX_W-1:0] ECHAN_RST  = 4'd8;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_THRESH = 1'b0;
  localparam logic [CFG_AW-1:0] REG_ECHAN  = 1'b1;

  typedef logic [NUM_CH-1:0][CH_W-1:0] ch_vals_t;

  // frame parser to result emitter
  typedef struct packed {
    logic done;     // one-cycle pulse: a good frame just completed
    logic link_ok;  // link state after that frame
  } frm_status_t;

endpackage

/* src/sfr_frame.sv */
// Byte parser: header hunt, frame collection, end/flag check and channel unpack.
module sfr_frame (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  input  logic                       emit_busy,
  output sfr_pkg::frm_status_t       status,
  output sfr_pkg::ch_vals_t          ch_vals
);
  import sfr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SR_W-1:0]  sr_r, sr_nxt;
  ch_vals_t         vals_r, vals_nxt;
  logic             link_r, link_nxt;
  logic             done_r, done_nxt;
  logic             accept;
  logic [BYTE_W-1:0] flag_byte;
  ch_vals_t         unpacked;

  // hold off only the end byte while the emitter still owns a frame
  assign in_tready = !(emit_busy && (pos_r == POS_END));
  assign accept    = in_tvalid && in_tready;
  assign flag_byte = sr_r[SR_W-1 -: BYTE_W];

  // bytes 1..22 form one little-endian bit string, 11 bits per channel
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      unpacked[ch] = sr_r[ch*CH_W +: CH_W];
    end
  end

  // parser next state
  always_comb begin
    pos_nxt  = pos_r;
    sr_nxt   = sr_r;
    vals_nxt = vals_r;
    link_nxt = link_r;
    done_nxt = 1'b0;
    if (accept) begin
      if (pos_r == POS_BAD) begin
        pos_nxt = POS_HUNT;
      end else if (pos_r == POS_HUNT) begin
        if (in_tdata == HEADER_BYTE) pos_nxt = pos_r + POS_W'(1);
      end else if (pos_r == POS_END) begin
        if (in_tdata == END_BYTE) begin
          pos_nxt  = POS_HUNT;
          done_nxt = 1'b1;
          if (flag_byte == '0) begin
            link_nxt = 1'b1;
            vals_nxt = unpacked;
          end else begin
            link_nxt = 1'b0;
          end
        end else begin
          pos_nxt = POS_BAD;
        end
      end else begin
        sr_nxt  = {in_tdata, sr_r[SR_W-1:BYTE_W]};
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      vals_r <= '0;
      link_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      vals_r <= vals_nxt;
      link_r <= link_nxt;
      done_r <= done_nxt;
    end
  end

  // frame byte line: payload only
  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  assign status.done    = done_r;
  assign status.link_ok = link_r;
  assign ch_vals        = vals_r;

endmodule

/* src/sfr_emit.sv */
// Result emitter: config registers, estop compare, channel snapshot and output register.
module sfr_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfr_pkg::frm_status_t       status,
  input  sfr_pkg::ch_vals_t          ch_vals,
  input  logic                       cfg_we,
  input  logic [sfr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [sfr_pkg::CH_W-1:0]   cfg_wdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sfr_pkg::OUT_DW-1:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                                 // [15] link_ok, [16] estop, [23:17] zero
  output logic                       out_tlast,
  output logic                       busy
);
  import sfr_pkg::*;

  logic [CH_W-1:0]   thresh_r;
  logic [IDX_W-1:0]  echan_r;
  ch_vals_t          snap_r, snap_nxt;
  logic              active_r, active_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              link_r, link_nxt;
  logic              estop_r, estop_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [OUT_DW-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  logic              load;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      echan_r  <= ECHAN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESH: thresh_r <= cfg_wdata;
        REG_ECHAN:  echan_r  <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign load = active_r && (!ovalid_r || out_tready);

  // burst sequencing: snapshot on frame done, shift one channel out per load
  always_comb begin
    snap_nxt   = snap_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    link_nxt   = link_r;
    estop_nxt  = estop_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (out_tready) ovalid_nxt = 1'b0;
    if (status.done) begin
      snap_nxt   = ch_vals;
      active_nxt = 1'b1;
      idx_nxt    = '0;
      link_nxt   = status.link_ok;
      estop_nxt  = ch_vals[echan_r] > thresh_r;
    end else if (load) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {(OUT_DW-IDX_W-CH_W-2)'(0), estop_r, link_r, snap_r[0], idx_r};
      olast_nxt  = (idx_r == IDX_W'(NUM_CH-1));
      snap_nxt   = ch_vals_t'({CH_W'(0), snap_r[NUM_CH-1:1]});
      idx_nxt    = idx_r + IDX_W'(1);
      if (idx_r == IDX_W'(NUM_CH-1)) active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    snap_r  <= snap_nxt;
    link_r  <= link_nxt;
    estop_r <= estop_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign busy       = status.done || active_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef ASSERT_OFF
  // parser must not finish a frame while a burst is still running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> !active_r)
    else $error("frame completed during an active burst");

  // a burst always starts at channel zero
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(active_r) |-> (idx_r == '0))
    else $error("burst did not start at channel zero");

  // a stalled item stays valid and unchanged
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output item changed while stalled");

  // last is flagged exactly on channel fifteen
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[IDX_W-1:0] == IDX_W'(NUM_CH-1))))
    else $error("tlast not aligned with channel fifteen");
`endif

endmodule

/* src/sbus_frame_receiver_top.sv */
// Top level of the SBUS frame receiver: parser plus result emitter.
//
// Usage: received UART bytes enter on the in_ stream, one byte per item. The
// parser hunts for the 0x0F header, collects the 25-byte frame, and checks
// the end byte. A good frame yields 16 result items on the out_ stream, one
// per channel in order, with tlast on channel fifteen; each carries the
// channel value, link_ok (flag byte was zero) and estop (watched channel
// above threshold, same in all 16 items).
// The done pulse for an accepted end byte loads the emitter snapshot; the output
// register then drains the burst at one item per cycle when out_tready is high.
// Throughput: one input byte per cycle. The parser registers and the emitter
// snapshot let bytes of the next frame flow in during a burst; only the end
// byte of a following frame is held off (in_tready low) while a burst is
// still pending, so a stalled receiver throttles input only at that point.
// Configuration: cfg_we writes estop_threshold (index 0) or estop_channel
// (index 1) from cfg_wdata; write only while the block is idle.
// Reset (rst_n low, synchronous): parser back to hunting, channel values
// and link state zero, threshold 800, watched channel 8, output empty.
module sbus_frame_receiver_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sfr_pkg::OUT_DW-1:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                                 // [15] link_ok, [16] estop, [23:17] zero
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [sfr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [sfr_pkg::CH_W-1:0]   cfg_wdata
);
  import sfr_pkg::*;

  frm_status_t status;
  ch_vals_t    ch_vals;
  logic        emit_busy;

  sfr_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .emit_busy (emit_busy),
    .status    (status),
    .ch_vals   (ch_vals)
  );

  sfr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .status     (status),
    .ch_vals    (ch_vals),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .busy       (emit_busy)
  );

endmodule
